// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, codes and sizes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int FILL_W      = 5;
  localparam int STATUS_W    = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_FULL      = 2'd3
  } spq_status_t;

  typedef logic [CNT_W-1:0] spq_cnt_t;

  // row-wide operation for one accepted transaction
  typedef struct packed {
    logic ins;
    logic rem;
  } spq_ctrl_t;

  // fill level reported modulo the field width
  function automatic logic [FILL_W-1:0] to_fill(input spq_cnt_t cnt);
    logic [CNT_W+FILL_W-1:0] tmp;
    begin
      tmp = {{FILL_W{1'b0}}, cnt};
      return tmp[FILL_W-1:0];
    end
  endfunction

endpackage

// File: rtl/spq_if.sv
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels for commands and results of the priority queue.
// ----------------------------------------------------------------------------
interface spq_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [spq_pkg::DATA_W-1:0] item_value;
  logic [spq_pkg::DATA_W-1:0] item_priority;

  modport source (output valid, cmd, item_value, item_priority, input ready);
  modport sink (input valid, cmd, item_value, item_priority, output ready);
endinterface

interface spq_out_if;
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::STATUS_W-1:0] status;
  logic [spq_pkg::DATA_W-1:0]   removed_value;
  logic [spq_pkg::FILL_W-1:0]   fill_level;

  modport source (output valid, status, removed_value, fill_level, input ready);
  modport sink (input valid, status, removed_value, fill_level, output ready);
endinterface

// File: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry, compares it with the incoming
// priority and takes the new entry or a neighbour's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                       clk,
  input  spq_pkg::spq_ctrl_t         ctrl,
  input  logic                       occ,
  input  logic [spq_pkg::DATA_W-1:0] new_prio,
  input  logic [spq_pkg::DATA_W-1:0] new_val,
  input  logic                       left_occ,
  input  logic                       left_greater,
  input  logic [spq_pkg::DATA_W-1:0] left_prio,
  input  logic [spq_pkg::DATA_W-1:0] left_val,
  input  logic [spq_pkg::DATA_W-1:0] right_prio,
  input  logic [spq_pkg::DATA_W-1:0] right_val,
  output logic                       greater,
  output logic [spq_pkg::DATA_W-1:0] prio,
  output logic [spq_pkg::DATA_W-1:0] val
);

  logic [spq_pkg::DATA_W-1:0] prio_r, prio_nxt;
  logic [spq_pkg::DATA_W-1:0] val_r, val_nxt;
  logic                       place;

  assign greater = occ && ($signed(prio_r) > $signed(new_prio));
  assign place   = (greater || !occ) && !left_greater && left_occ;

  always_comb begin
    prio_nxt = prio_r;
    val_nxt  = val_r;
    priority if (ctrl.rem) begin
      prio_nxt = right_prio;
      val_nxt  = right_val;
    end else if (ctrl.ins && left_greater) begin
      prio_nxt = left_prio;
      val_nxt  = left_val;
    end else if (ctrl.ins && place) begin
      prio_nxt = new_prio;
      val_nxt  = new_val;
    end else begin
      prio_nxt = prio_r;
      val_nxt  = val_r;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    val_r  <= val_nxt;
  end

  assign prio = prio_r;
  assign val  = val_r;

endmodule

// File: rtl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded stable priority queue built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// One command transaction is taken per clock while the result register is
// free or being drained, so the queue sustains one insert or remove per
// cycle; each result is registered and shows in the cycle after its command.
// All cells compare the incoming priority at once and shift right on insert
// or left on remove in that same cycle. Smaller priority leaves first, equal
// priorities leave in arrival order; remove on empty reports underflow and
// insert on full is dropped and flagged. Cell contents are not cleared by
// reset: the fill count alone marks which cells hold entries.
module sorted_priority_queue_unit (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_chan,
  spq_out_if.source out_chan
);

  localparam int D = spq_pkg::QUEUE_DEPTH;

  spq_pkg::spq_cnt_t          occ_r, occ_nxt;
  logic                       out_valid_r;
  spq_pkg::spq_status_t       out_status_r, out_status_nxt;
  logic [spq_pkg::DATA_W-1:0] out_removed_r, out_removed_nxt;
  logic [spq_pkg::FILL_W-1:0] out_fill_r;

  logic                       accept, full, empty;
  spq_pkg::spq_ctrl_t         ctrl;
  logic [D-1:0]               occupied, greater;
  logic [spq_pkg::DATA_W-1:0] prio [D];
  logic [spq_pkg::DATA_W-1:0] val  [D];

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign full          = (occ_r == spq_pkg::spq_cnt_t'(D));
  assign empty         = (occ_r == '0);
  assign ctrl.ins      = accept && (in_chan.cmd == spq_pkg::CMD_INSERT) && !full;
  assign ctrl.rem      = accept && (in_chan.cmd == spq_pkg::CMD_REMOVE) && !empty;

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic                       l_occ, l_greater;
    logic [spq_pkg::DATA_W-1:0] l_prio, l_val, r_prio, r_val;

    assign occupied[i] = (spq_pkg::spq_cnt_t'(i) < occ_r);

    if (i == 0) begin : g_head
      assign l_occ     = 1'b1;
      assign l_greater = 1'b0;
      assign l_prio    = '0;
      assign l_val     = '0;
    end else begin : g_body
      assign l_occ     = occupied[i-1];
      assign l_greater = greater[i-1];
      assign l_prio    = prio[i-1];
      assign l_val     = val[i-1];
    end

    if (i == D - 1) begin : g_tail
      assign r_prio = '0;
      assign r_val  = '0;
    end else begin : g_link
      assign r_prio = prio[i+1];
      assign r_val  = val[i+1];
    end

    spq_cell u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .occ          (occupied[i]),
      .new_prio     (in_chan.item_priority),
      .new_val      (in_chan.item_value),
      .left_occ     (l_occ),
      .left_greater (l_greater),
      .left_prio    (l_prio),
      .left_val     (l_val),
      .right_prio   (r_prio),
      .right_val    (r_val),
      .greater      (greater[i]),
      .prio         (prio[i]),
      .val          (val[i])
    );
  end

  always_comb begin
    occ_nxt         = occ_r;
    out_removed_nxt = '0;
    if (in_chan.cmd == spq_pkg::CMD_INSERT) begin
      out_status_nxt = full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
    end else begin
      out_status_nxt = empty ? spq_pkg::ST_UNDERFLOW : spq_pkg::ST_REMOVED;
    end
    priority if (ctrl.ins) begin
      occ_nxt = occ_r + spq_pkg::spq_cnt_t'(1);
    end else if (ctrl.rem) begin
      occ_nxt         = occ_r - spq_pkg::spq_cnt_t'(1);
      out_removed_nxt = val[0];
    end else begin
      occ_nxt = occ_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r  <= out_status_nxt;
      out_removed_r <= out_removed_nxt;
      out_fill_r    <= spq_pkg::to_fill(occ_nxt);
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.removed_value = out_removed_r;
  assign out_chan.fill_level    = out_fill_r;

endmodule

// File: tb/tb_sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_unit
// Self-checking bench for the bounded stable priority queue. Inserts and
// removes are driven over the command channel while a local copy of the queue
// predicts status, removed value and fill level for every accepted command.
// Results are checked in order, under phases with and without sender gaps and
// receiver stalls, with insert-heavy and remove-heavy bursts.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_unit;
  import spq_pkg::*;

  localparam int PHASE_ITEMS   = 282;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    spq_status_t         status;
    logic [DATA_W-1:0]   removed_value;
    logic [FILL_W-1:0]   fill_level;
  } spq_outcome_t;

  logic clk;
  logic rst_n;

  spq_in_if  in_chan ();
  spq_out_if out_chan ();

  sorted_priority_queue_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic signed [DATA_W-1:0] shadow_prio [QUEUE_DEPTH];
  logic [DATA_W-1:0]        shadow_value [QUEUE_DEPTH];
  int                       shadow_count;
  spq_outcome_t             due_outcomes[$];
  int                       error_count;
  int                       send_idle_pct;
  int                       recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  // apply one command to the shadow queue and return its outcome
  function automatic spq_outcome_t apply_queue_op(input logic op,
                                                  input logic [DATA_W-1:0] value,
                                                  input logic signed [DATA_W-1:0] prio);
    spq_outcome_t res;
    int           pos;
    int           k;
    res.removed_value = '0;
    if (op == CMD_INSERT) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] <= prio) pos++;
        for (k = shadow_count; k > pos; k--) begin
          shadow_prio[k]  = shadow_prio[k-1];
          shadow_value[k] = shadow_value[k-1];
        end
        shadow_prio[pos]  = prio;
        shadow_value[pos] = value;
        shadow_count++;
        res.status = ST_INSERTED;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = ST_UNDERFLOW;
      end else begin
        res.removed_value = shadow_value[0];
        for (k = 1; k < shadow_count; k++) begin
          shadow_prio[k-1]  = shadow_prio[k];
          shadow_value[k-1] = shadow_value[k];
        end
        shadow_count--;
        res.status = ST_REMOVED;
      end
    end
    res.fill_level = shadow_count[FILL_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    spq_outcome_t want;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        due_outcomes.push_back(apply_queue_op(in_chan.cmd, in_chan.item_value,
                                              in_chan.item_priority));
      end
      if (out_chan.valid && out_chan.ready) begin
        if (due_outcomes.size() == 0) begin
          $display("%0t: unexpected transaction: status %0d removed_value %0d fill_level %0d",
                   $time, out_chan.status, $signed(out_chan.removed_value),
                   out_chan.fill_level);
          error_count++;
        end else begin
          want = due_outcomes.pop_front();
          if (out_chan.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_chan.status);
            error_count++;
          end
          if (out_chan.removed_value !== want.removed_value) begin
            $display("%0t: removed_value expected %0d actual %0d", $time,
                     $signed(want.removed_value), $signed(out_chan.removed_value));
            error_count++;
          end
          if (out_chan.fill_level !== want.fill_level) begin
            $display("%0t: fill_level expected %0d actual %0d", $time,
                     want.fill_level, out_chan.fill_level);
            error_count++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_op(input logic op, input logic [DATA_W-1:0] value,
                         input logic [DATA_W-1:0] prio);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.cmd           <= op;
    in_chan.item_value    <= value;
    in_chan.item_priority <= prio;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (due_outcomes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_extreme();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return 32'h8000_0001;
      default: return 32'h7fff_fffe;
    endcase
  endfunction

  // narrow range in four of ten draws so equal priorities are common
  function automatic logic [DATA_W-1:0] pick_priority();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(8) - 4;
      4, 5:       return pick_extreme();
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(9) == 0) return pick_extreme();
    return $urandom;
  endfunction

  task automatic test_empty_remove();
    send_op(CMD_REMOVE, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_order_and_full();
    logic [DATA_W-1:0] dir_prio [16];
    logic [DATA_W-1:0] dir_value [16];
    int i;
    dir_prio = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                 32'h8000_0000, 32'h7fff_ffff, 32'd5, 32'd5,
                 32'd5, 32'h0000_0000, 32'h8000_0001, 32'h7fff_fffe,
                 32'hffff_ffff, 32'd3, 32'd3, 32'd7};
    dir_value = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                  32'h0000_0001, 32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0002,
                  32'h0000_0003, 32'h1234_5678, 32'hdead_beef, 32'hfedc_ba98,
                  32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h0000_0004, 32'h7fff_fffe};
    for (i = 0; i < 16; i++) send_op(CMD_INSERT, dir_value[i], dir_prio[i]);
    // full queue drops the insert
    send_op(CMD_INSERT, 32'h1111_1111, 32'h8000_0000);
    for (i = 0; i < 4; i++) send_op(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
  endtask

  task automatic run_bursts(input int n_items, input int idle_pct, input int stall_pct);
    int sent;
    int burst_len;
    int insert_pct;
    int i;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      burst_len = $urandom_range(24, 1);
      case ($urandom_range(4))
        0, 1:    insert_pct = 85;
        2, 3:    insert_pct = 15;
        default: insert_pct = 50;
      endcase
      for (i = 0; i < burst_len && sent < n_items; i++) begin
        send_op(($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE,
                pick_value(), pick_priority());
        sent++;
      end
    end
    pause_until_drained();
  endtask

  task automatic test_no_idling();
    run_bursts(PHASE_ITEMS, 0, 0);
  endtask

  task automatic test_sender_idle();
    run_bursts(PHASE_ITEMS, 45, 0);
  endtask

  task automatic test_receiver_stall();
    run_bursts(PHASE_ITEMS, 0, 45);
  endtask

  task automatic test_both_idle();
    run_bursts(PHASE_ITEMS, 8, 8);
  endtask

  initial begin
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.cmd           = CMD_INSERT;
    in_chan.item_value    = '0;
    in_chan.item_priority = '0;
    out_chan.ready        = 1'b0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    shadow_count          = 0;
    error_count           = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_remove();
    test_order_and_full();
    pause_until_drained();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();

    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
